>>> rtl/swik_pkg.sv
// swik_pkg: shared types, constants, microcode and tables of the swerve kinematics block
`default_nettype none

package swik_pkg;

    localparam int MOD_COUNT   = 4;
    localparam int MOD_W       = 2;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_W        = 16;
    localparam int COMP_W      = 18;
    localparam int PROD_W      = 36;
    localparam int CX_W        = 28;
    localparam int Z_W         = 20;
    localparam int ANG_W       = 16;
    localparam int SPD_W       = 16;
    localparam int SQ_W        = 36;
    localparam int SQ_TOP      = 34;
    localparam int SQRT_ITERS  = 18;
    localparam int ATAN_IDX_W  = 5;
    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q16 = 102944;
    localparam int ROUND_Q14   = 8192;
    localparam int PC_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WHEEL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK_WIDTH = 1'd1;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_LOAD = 3'd0;
    localparam pc_t PC_MTY  = 3'd1;
    localparam pc_t PC_MTX  = 3'd2;
    localparam pc_t PC_FORM = 3'd3;
    localparam pc_t PC_SQX  = 3'd4;
    localparam pc_t PC_SQY  = 3'd5;
    localparam pc_t PC_ITER = 3'd6;
    localparam pc_t PC_EMIT = 3'd7;

    typedef struct packed {
        logic signed [IN_W-1:0] x_speed;
        logic signed [IN_W-1:0] y_speed;
        logic signed [IN_W-1:0] turn_rate;
    } in_word_t;

    typedef struct packed {
        logic [MOD_W-1:0]        module_index;
        logic [SPD_W-1:0]        wheel_speed;
        logic signed [ANG_W-1:0] steer_angle;
        logic                    last_module;
    } out_word_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_MUL_TY,
        OP_MUL_TX,
        OP_FORM,
        OP_SQ_X,
        OP_SQ_Y,
        OP_ITER,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_ZERO,
        COND_LOOP,
        COND_EMIT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        logic zero;
        logic iter_done;
        logic last;
    } stat_t;

    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        unique case (pc)
            PC_LOAD: w = '{op: OP_LOAD,   cond: COND_WAIT_IN, target: PC_LOAD};
            PC_MTY:  w = '{op: OP_MUL_TY, cond: COND_NEXT,    target: PC_LOAD};
            PC_MTX:  w = '{op: OP_MUL_TX, cond: COND_NEXT,    target: PC_LOAD};
            PC_FORM: w = '{op: OP_FORM,   cond: COND_NEXT,    target: PC_LOAD};
            PC_SQX:  w = '{op: OP_SQ_X,   cond: COND_NEXT,    target: PC_LOAD};
            PC_SQY:  w = '{op: OP_SQ_Y,   cond: COND_ZERO,    target: PC_EMIT};
            PC_ITER: w = '{op: OP_ITER,   cond: COND_LOOP,    target: PC_LOAD};
            PC_EMIT: w = '{op: OP_EMIT,   cond: COND_EMIT,    target: PC_FORM};
            default: w = '{op: OP_LOAD,   cond: COND_WAIT_IN, target: PC_LOAD};
        endcase
        return w;
    endfunction

    // round(atan(2^-i) * 2^16)
    function automatic logic [15:0] atan_q16(logic [ATAN_IDX_W-1:0] i);
        logic [15:0] a;
        case (i)
            5'd0:    a = 16'd51472;
            5'd1:    a = 16'd30386;
            5'd2:    a = 16'd16055;
            5'd3:    a = 16'd8150;
            5'd4:    a = 16'd4091;
            5'd5:    a = 16'd2047;
            5'd6:    a = 16'd1024;
            5'd7:    a = 16'd512;
            5'd8:    a = 16'd256;
            5'd9:    a = 16'd128;
            5'd10:   a = 16'd64;
            5'd11:   a = 16'd32;
            5'd12:   a = 16'd16;
            5'd13:   a = 16'd8;
            5'd14:   a = 16'd4;
            5'd15:   a = 16'd2;
            5'd16:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // front left and rear left subtract the wheel base term
    function automatic logic y_neg(logic [MOD_W-1:0] k);
        return (k == 2'd0) || (k == 2'd1);
    endfunction

    // front left and front right subtract the track width term
    function automatic logic x_neg(logic [MOD_W-1:0] k);
        return (k == 2'd0) || (k == 2'd3);
    endfunction

endpackage

`default_nettype wire

>>> rtl/swik_seq.sv
// swik_seq: microprogram counter, control store and branch logic
`default_nettype none

module swik_seq (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          out_free,
    input  wire swik_pkg::stat_t stat,
    output swik_pkg::ctrl_t    ctrl
);
    import swik_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;

    assign uw = ucode(pc_reg);

    always_comb begin
        pc_next = PC_W'(pc_reg + 1'b1);
        unique case (uw.cond)
            COND_NEXT: begin
                pc_next = PC_W'(pc_reg + 1'b1);
            end
            COND_WAIT_IN: begin
                if (!s_valid) begin
                    pc_next = pc_reg;
                end
            end
            COND_ZERO: begin
                if (stat.zero) begin
                    pc_next = uw.target;
                end
            end
            COND_LOOP: begin
                if (!stat.iter_done) begin
                    pc_next = pc_reg;
                end
            end
            COND_EMIT: begin
                if (!out_free) begin
                    pc_next = pc_reg;
                end else if (stat.last) begin
                    pc_next = PC_LOAD;
                end else begin
                    pc_next = uw.target;
                end
            end
            default: begin
                pc_next = PC_LOAD;
            end
        endcase
    end

    always_comb begin
        ctrl.op = uw.op;
        unique case (uw.cond)
            COND_WAIT_IN: ctrl.fire = s_valid;
            COND_EMIT:    ctrl.fire = out_free;
            default:      ctrl.fire = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/swik_dpath.sv
// swik_dpath: shared multiplier, cordic vectoring unit, square root unit and held angles
`default_nettype none

module swik_dpath #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire swik_pkg::ctrl_t          ctrl,
    input  wire swik_pkg::in_word_t       in_word,
    input  wire logic [swik_pkg::CFG_W-1:0] hwb,
    input  wire logic [swik_pkg::CFG_W-1:0] htw,
    output swik_pkg::stat_t               stat,
    output swik_pkg::out_word_t           res
);
    import swik_pkg::*;

    localparam int ITER_COUNT = (CORDIC_STAGES > SQRT_ITERS) ? CORDIC_STAGES : SQRT_ITERS;
    localparam int CNT_W      = $clog2(ITER_COUNT);

    logic signed [IN_W-1:0]   x_reg, x_next;
    logic signed [IN_W-1:0]   y_reg, y_next;
    logic signed [IN_W-1:0]   w_reg, w_next;
    logic signed [COMP_W-1:0] ty_reg, ty_next;
    logic signed [COMP_W-1:0] tx_reg, tx_next;
    logic signed [COMP_W-1:0] cx_reg, cx_next;
    logic signed [COMP_W-1:0] cy_reg, cy_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [SQ_W-1:0]          rem_reg, rem_next;
    logic [SQ_W-1:0]          root_reg, root_next;
    logic signed [CX_W-1:0]   xc_reg, xc_next;
    logic signed [CX_W-1:0]   yc_reg, yc_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [MOD_W-1:0]         mod_reg, mod_next;
    logic signed [ANG_W-1:0]  held_reg [MOD_COUNT];
    logic                     held_we;

    logic signed [COMP_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] offs_full;
    logic signed [COMP_W-1:0] offs;
    logic signed [COMP_W-1:0] xw, yw;
    logic signed [CX_W-1:0]   xa, ya;
    logic signed [CX_W-1:0]   xsh, ysh;
    logic signed [Z_W-1:0]    da;
    logic                     cordic_on, sqrt_on;
    logic [5:0]               sqsh;
    logic [SQ_W-1:0]          bitv, trial;
    logic [SQ_W-1:0]          rnd;
    logic [SPD_W-1:0]         spd;
    logic signed [Z_W-1:0]    zr;
    logic signed [ANG_W-1:0]  ang;
    logic                     zero;

    always_comb begin
        unique case (ctrl.op)
            OP_MUL_TY: begin
                mul_a = COMP_W'(w_reg);
                mul_b = $signed({3'b000, hwb});
            end
            OP_MUL_TX: begin
                mul_a = COMP_W'(w_reg);
                mul_b = $signed({3'b000, htw});
            end
            OP_SQ_X: begin
                mul_a = cx_reg;
                mul_b = cx_reg;
            end
            default: begin
                mul_a = cy_reg;
                mul_b = cy_reg;
            end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign offs_full = (prod + PROD_W'(ROUND_Q14)) >>> 14;
    assign offs      = offs_full[COMP_W-1:0];

    assign xw = COMP_W'(x_reg);
    assign yw = COMP_W'(y_reg);

    assign zero = (cx_reg == '0) && (cy_reg == '0);

    // vector scaled by 256 before the cordic pass
    assign xa = CX_W'($signed({cx_reg, 8'b0}));
    assign ya = CX_W'($signed({cy_reg, 8'b0}));

    assign xsh       = xc_reg >>> cnt_reg;
    assign ysh       = yc_reg >>> cnt_reg;
    assign da        = Z_W'($signed({1'b0, atan_q16(ATAN_IDX_W'(cnt_reg))}));
    assign cordic_on = int'(cnt_reg) < CORDIC_STAGES;
    assign sqrt_on   = int'(cnt_reg) < SQRT_ITERS;
    assign sqsh      = 6'(SQ_TOP - 2 * int'(cnt_reg));
    assign bitv      = SQ_W'(1) << sqsh;
    assign trial     = root_reg + bitv;

    assign rnd = root_reg + SQ_W'(rem_reg > root_reg);
    assign spd = (rnd > SQ_W'(16'hFFFF)) ? '1 : rnd[SPD_W-1:0];

    assign zr = (z_reg + Z_W'(4)) >>> 3;

    always_comb begin
        if (zr > Z_W'(PI_Q13)) begin
            ang = ANG_W'(PI_Q13);
        end else if (zr < Z_W'(-PI_Q13)) begin
            ang = ANG_W'(-PI_Q13);
        end else begin
            ang = zr[ANG_W-1:0];
        end
    end

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        w_next    = w_reg;
        ty_next   = ty_reg;
        tx_next   = tx_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        sq_next   = sq_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        xc_next   = xc_reg;
        yc_next   = yc_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        held_we   = 1'b0;
        unique case (ctrl.op)
            OP_LOAD: begin
                if (ctrl.fire) begin
                    x_next = in_word.x_speed;
                    y_next = in_word.y_speed;
                    w_next = in_word.turn_rate;
                end
            end
            OP_MUL_TY: begin
                ty_next = offs;
            end
            OP_MUL_TX: begin
                tx_next  = offs;
                mod_next = '0;
            end
            OP_FORM: begin
                cy_next = y_neg(mod_reg) ? yw - ty_reg : yw + ty_reg;
                cx_next = x_neg(mod_reg) ? xw - tx_reg : xw + tx_reg;
            end
            OP_SQ_X: begin
                sq_next = SQ_W'(prod);
            end
            OP_SQ_Y: begin
                rem_next  = sq_reg + SQ_W'(prod);
                root_next = '0;
                cnt_next  = '0;
                if (xa < 0) begin
                    if (ya >= 0) begin
                        xc_next = ya;
                        yc_next = -xa;
                        z_next  = Z_W'(HALF_PI_Q16);
                    end else begin
                        xc_next = -ya;
                        yc_next = xa;
                        z_next  = Z_W'(-HALF_PI_Q16);
                    end
                end else begin
                    xc_next = xa;
                    yc_next = ya;
                    z_next  = '0;
                end
            end
            OP_ITER: begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cordic_on) begin
                    if (yc_reg >= 0) begin
                        xc_next = xc_reg + ysh;
                        yc_next = yc_reg - xsh;
                        z_next  = z_reg + da;
                    end else begin
                        xc_next = xc_reg - ysh;
                        yc_next = yc_reg + xsh;
                        z_next  = z_reg - da;
                    end
                end
                if (sqrt_on) begin
                    if (rem_reg >= trial) begin
                        rem_next  = rem_reg - trial;
                        root_next = (root_reg >> 1) + bitv;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                end
            end
            OP_EMIT: begin
                if (ctrl.fire) begin
                    mod_next = MOD_W'(mod_reg + 1'b1);
                    held_we  = !zero;
                end
            end
            default: begin
                mod_next = mod_reg;
            end
        endcase
    end

    always_comb begin
        res.module_index = mod_reg;
        res.wheel_speed  = zero ? '0 : spd;
        res.steer_angle  = zero ? held_reg[mod_reg] : ang;
        res.last_module  = (mod_reg == MOD_W'(MOD_COUNT - 1));
    end

    assign stat.zero      = zero;
    assign stat.iter_done = (cnt_reg == CNT_W'(ITER_COUNT - 1));
    assign stat.last      = (mod_reg == MOD_W'(MOD_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            mod_reg <= '0;
            for (int k = 0; k < MOD_COUNT; k++) begin
                held_reg[k] <= '0;
            end
        end else begin
            cnt_reg <= cnt_next;
            mod_reg <= mod_next;
            if (held_we) begin
                held_reg[mod_reg] <= ang;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        w_reg    <= w_next;
        ty_reg   <= ty_next;
        tx_reg   <= tx_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        xc_reg   <= xc_next;
        yc_reg   <= yc_next;
        z_reg    <= z_next;
    end

endmodule

`default_nettype wire

>>> rtl/swerve_inverse_kinematics.sv
// swerve_inverse_kinematics: top level, configuration registers and result register
//
//  port group   dir  contents
//  s_*          in   chassis command word: x_speed, y_speed, turn_rate
//  m_*          out  module result word: module_index, wheel_speed, steer_angle, last_module
//  cfg_*        in   register write: half_wheel_base (0), half_track_width (1)
//
// a command runs through load and the two offset multiplies, then per module the form
// step, two square steps, the shared cordic / square root iteration loop and emit; a
// module with both components zero skips the iteration loop and goes straight to emit
// synchronous reset clears the sequencer, the result valid flag and the held angles
// a held result word stalls the sequencer at its emit step; the next command is
// accepted while the last result word still waits
`default_nettype none

module swerve_inverse_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire swik_pkg::in_word_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output swik_pkg::out_word_t                m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [swik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swik_pkg::CFG_W-1:0]     cfg_data
);
    import swik_pkg::*;

    logic [CFG_W-1:0] hwb_reg, hwb_next;
    logic [CFG_W-1:0] htw_reg, htw_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;
    logic             out_free;
    logic             emit_go;
    ctrl_t            ctrl;
    stat_t            stat;
    out_word_t        res;

    swik_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    swik_dpath #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .in_word (s_data),
        .hwb     (hwb_reg),
        .htw     (htw_reg),
        .stat    (stat),
        .res     (res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign emit_go  = (ctrl.op == OP_EMIT) && ctrl.fire;
    assign s_ready  = (ctrl.op == OP_LOAD);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        hwb_next = hwb_reg;
        htw_next = htw_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HALF_WHEEL_BASE:  hwb_next = cfg_data;
                REG_HALF_TRACK_WIDTH: htw_next = cfg_data;
                default:              hwb_next = hwb_reg;
            endcase
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit_go) begin
            m_data_next  = res;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwb_reg     <= CFG_W'(4096);
            htw_reg     <= CFG_W'(4096);
            m_valid_reg <= 1'b0;
        end else begin
            hwb_reg     <= hwb_next;
            htw_reg     <= htw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // not ready in the cycle after taking a command
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer ready right after a command was taken");

    // after the fourth result is loaded the sequencer is back at its load step
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go && res.last_module |=> s_ready)
        else $error("sequencer not back at load after last module");

    // emitted angle stays within minus pi to pi
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.steer_angle) <= $signed(ANG_W'(PI_Q13)))
            && ($signed(m_data.steer_angle) >= $signed(ANG_W'(-PI_Q13))))
        else $error("steer angle out of range");

    // a zero speed result is only emitted for a module whose components are both zero
    a_zero_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go && !stat.zero && (res.wheel_speed == '0) |-> 1'b0)
        else $error("nonzero vector gave zero wheel speed");

endmodule

`default_nettype wire

>>> bench/swerve_inverse_kinematics_test.sv
// swerve_inverse_kinematics_test: self-checking bench with driver, monitor and predictor
module swerve_inverse_kinematics_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swik_pkg::*;

    localparam int  STAGES       = 16;
    localparam real HALF_PERIOD  = 4.0;
    localparam int  IDLE_PCT     = 29;
    localparam int  STALL_LIMIT  = 4000;
    localparam int  SETTLE_TICKS = 100;

    localparam longint ATAN_Q16 [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int Y_SIGN [4] = '{-1, -1, 1, 1};
    localparam int X_SIGN [4] = '{-1, 1, 1, -1};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HALF_WHEEL_BASE;
    logic [CFG_W-1:0]   cfg_data = '0;

    in_word_t           commands_to_send [$];
    out_word_t          expected_modules [$];
    logic [CFG_W-1:0]   wheel_base_q = 15'd4096;
    logic [CFG_W-1:0]   track_width_q = 15'd4096;
    logic signed [ANG_W-1:0] held_steer [4] = '{default: '0};
    int                 errors = 0;
    int                 stall_ticks = 0;
    bit                 steady = 1'b0;

    swerve_inverse_kinematics #(.CORDIC_STAGES(STAGES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic longint offset_term(logic signed [IN_W-1:0] rate, logic [CFG_W-1:0] len);
        longint p;
        p = longint'(rate) * longint'({1'b0, len});
        return (p + 64'sd8192) >>> 14;
    endfunction

    function automatic logic [SPD_W-1:0] speed_of(longint cx, longint cy);
        longint unsigned s;
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        s = longint'(cx * cx) + longint'(cy * cy);
        rem = s;
        r = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s > r * r + r) r = r + 1;
        if (r > 64'd65535) r = 64'd65535;
        return r[SPD_W-1:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] steer_of(longint cx, longint cy);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        x = cx * 256;
        y = cy * 256;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = HALF_PI_Q16;
            end else begin
                x = -y;
                y = t;
                z = -HALF_PI_Q16;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[i];
            end
        end
        z = (z + 4) >>> 3;
        if (z > PI_Q13) z = PI_Q13;
        if (z < -PI_Q13) z = -PI_Q13;
        return z[ANG_W-1:0];
    endfunction

    task automatic compute_module_vectors(in_word_t cmd);
        longint ty;
        longint tx;
        longint cy;
        longint cx;
        out_word_t w;
        ty = offset_term(cmd.turn_rate, wheel_base_q);
        tx = offset_term(cmd.turn_rate, track_width_q);
        for (int k = 0; k < MOD_COUNT; k++) begin
            cy = longint'(cmd.y_speed) + Y_SIGN[k] * ty;
            cx = longint'(cmd.x_speed) + X_SIGN[k] * tx;
            w.module_index = k[MOD_W-1:0];
            w.last_module  = (k == MOD_COUNT - 1);
            if (cx == 0 && cy == 0) begin
                w.wheel_speed = '0;
                w.steer_angle = held_steer[k];
            end else begin
                w.wheel_speed = speed_of(cx, cy);
                w.steer_angle = steer_of(cx, cy);
                held_steer[k] = w.steer_angle;
            end
            expected_modules.push_back(w);
        end
    endtask

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) compute_module_vectors(s_data);
            if (!s_valid || s_ready) begin
                if (commands_to_send.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= commands_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                if (expected_modules.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word: expected none, actual %p", $time, m_data);
                end else begin
                    want = expected_modules.pop_front();
                    if (m_data.module_index !== want.module_index) begin
                        errors++;
                        $display("%0t module_index: expected %0d, actual %0d",
                                 $time, want.module_index, m_data.module_index);
                    end
                    if (m_data.wheel_speed !== want.wheel_speed) begin
                        errors++;
                        $display("%0t wheel_speed (module %0d): expected %0d, actual %0d",
                                 $time, want.module_index, want.wheel_speed,
                                 m_data.wheel_speed);
                    end
                    if (m_data.steer_angle !== want.steer_angle) begin
                        errors++;
                        $display("%0t steer_angle (module %0d): expected %0d, actual %0d",
                                 $time, want.module_index, want.steer_angle,
                                 m_data.steer_angle);
                    end
                    if (m_data.last_module !== want.last_module) begin
                        errors++;
                        $display("%0t last_module (module %0d): expected %0b, actual %0b",
                                 $time, want.module_index, want.last_module,
                                 m_data.last_module);
                    end
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (commands_to_send.size() == 0 && !s_valid && expected_modules.size() == 0)) begin
            stall_ticks <= 0;
        end else if (stall_ticks >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_ticks <= stall_ticks + 1;
        end
    end

    function automatic in_word_t pack_cmd(longint x, longint y, longint w);
        in_word_t c;
        c.x_speed   = x[IN_W-1:0];
        c.y_speed   = y[IN_W-1:0];
        c.turn_rate = w[IN_W-1:0];
        return c;
    endfunction

    function automatic in_word_t random_cmd();
        int kind;
        int k;
        longint x;
        longint y;
        longint w;
        kind = $urandom_range(99);
        if (kind < 50) begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
            w = $signed(16'($urandom));
        end else if (kind < 70) begin
            x = $urandom_range(600) - 300;
            y = $urandom_range(600) - 300;
            w = $urandom_range(600) - 300;
        end else if (kind < 85) begin
            // one module with both components cancelled
            k = $urandom_range(3);
            w = $urandom_range(16000) - 8000;
            y = -Y_SIGN[k] * offset_term(w[IN_W-1:0], wheel_base_q);
            x = -X_SIGN[k] * offset_term(w[IN_W-1:0], track_width_q);
        end else begin
            // pure translation along an axis
            w = 0;
            if ($urandom_range(1)) begin
                x = $signed(16'($urandom));
                y = 0;
            end else begin
                x = 0;
                y = $signed(16'($urandom));
            end
        end
        return pack_cmd(x, y, w);
    endfunction

    task automatic wait_drained();
        while (commands_to_send.size() != 0 || s_valid || expected_modules.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_HALF_WHEEL_BASE) wheel_base_q = val;
        else if (idx == REG_HALF_TRACK_WIDTH) track_width_q = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(logic [CFG_W-1:0] wb, logic [CFG_W-1:0] tw);
        wait_drained();
        write_reg(REG_HALF_WHEEL_BASE, wb);
        write_reg(REG_HALF_TRACK_WIDTH, tw);
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++) commands_to_send.push_back(random_cmd());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: offsets are a quarter of the turn rate
        commands_to_send.push_back(pack_cmd(0, 0, 0));
        commands_to_send.push_back(pack_cmd(-100, 0, 0));
        commands_to_send.push_back(pack_cmd(100, 0, 0));
        commands_to_send.push_back(pack_cmd(0, 100, 0));
        commands_to_send.push_back(pack_cmd(0, -100, 0));
        commands_to_send.push_back(pack_cmd(-100, -1, 0));
        commands_to_send.push_back(pack_cmd(100, 100, 400));
        commands_to_send.push_back(pack_cmd(-100, 100, -400));
        commands_to_send.push_back(pack_cmd(0, 0, 0));
        commands_to_send.push_back(pack_cmd(32767, 32767, 32767));
        commands_to_send.push_back(pack_cmd(-32768, -32768, -32768));
        commands_to_send.push_back(pack_cmd(32767, -32768, 0));
        commands_to_send.push_back(pack_cmd(-32768, 32767, -32768));
        commands_to_send.push_back(pack_cmd(0, 0, 32767));
        commands_to_send.push_back(pack_cmd(0, 0, -32768));
        commands_to_send.push_back(pack_cmd(-32768, 0, 0));
        commands_to_send.push_back(pack_cmd(1, 0, 0));
        commands_to_send.push_back(pack_cmd(-1, 0, 0));
        commands_to_send.push_back(pack_cmd(0, -1, 0));
        commands_to_send.push_back(pack_cmd(-1, -1, 1));

        set_geometry(15'd32767, 15'd32767);
        commands_to_send.push_back(pack_cmd(32767, 32767, 32767));
        commands_to_send.push_back(pack_cmd(-32768, -32768, 32767));
        commands_to_send.push_back(pack_cmd(32767, -32768, -32768));
        queue_random(32);

        set_geometry(15'd0, 15'd0);
        queue_random(36);

        set_geometry(15'd0, 15'd32767);
        steady = 1'b1;
        queue_random(36);
        wait_drained();
        steady = 1'b0;

        set_geometry(15'd32767, 15'd0);
        queue_random(36);

        set_geometry(15'($urandom), 15'($urandom));
        queue_random(36);

        set_geometry(15'd4096, 15'd6000);
        queue_random(36);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (errors == 0 && expected_modules.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/swik_pkg.sv
rtl/swik_seq.sv
rtl/swik_dpath.sv
rtl/swerve_inverse_kinematics.sv
bench/swerve_inverse_kinematics_test.sv
